[hw/rtl/gzhp_pkg.sv]
// Shared types and constants for the gzip header name padder.
// No dependencies; imported by the padder unit and its checker.
`timescale 1ns / 1ps

package gzhp_pkg;

    // Header bytes recognised in the stream
    localparam logic [7:0] GZ_MAGIC1       = 8'h1F;
    localparam logic [7:0] GZ_MAGIC2       = 8'h8B;
    localparam logic [7:0] GZ_METHOD_DEFL  = 8'h08;
    localparam logic [7:0] GZ_FLAG_FNAME   = 8'h08;
    localparam logic [7:0] GZ_NUL          = 8'h00;
    localparam logic [7:0] GZ_PAD_CHAR     = 8'h61;   // letter a
    localparam logic [2:0] GZ_HEADER_BYTES = 3'd6;    // MTIME, XFL, OS

    // Configuration register indexes
    localparam logic CFG_PAD_COUNT = 1'b0;
    localparam logic CFG_BYPASS    = 1'b1;

    // Result tdata layout
    localparam int OUT_BYTE_LSB = 0;
    localparam int OUT_HAS_BIT  = 8;
    localparam int OUT_ERR_LSB  = 9;
    localparam int OUT_LAST_BIT = 12;
    localparam int OUT_TDATA_W  = 16;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_MAGIC1 = 3'd1,
        ERR_MAGIC2 = 3'd2,
        ERR_METHOD = 3'd3,
        ERR_FLAG   = 3'd4
    } err_code_t;

endpackage

[hw/rtl/gzip_header_name_padder_unit.sv]
// gzip header name padder: top level, rewrites the FNAME field of a gzip byte stream.
// Depends on gzhp_pkg.
`timescale 1ns / 1ps

// One byte of the gzip stream enters per request on the s_ side and, on the m_ side,
// one result per cycle leaves while m_tready is high. Bytes first land in a two-deep
// input buffer whose ready is registered, so the input keeps moving while a result
// waits to be taken. A single decode step then checks the magic bytes and method,
// rewrites a zero flag byte to FNAME, drops any old name up to its NUL and loads the
// output register. An ordinary byte passes through the input buffer and then the
// output register. The byte that inserts the padding name, if it is emitted itself,
// is followed by min(pad_count, MAX_PAD) pad characters and a NUL; no new byte is
// decoded until that burst is done, and the input buffer fills behind it.
// An error gives one result with has_byte clear and tlast set; the rest of that
// file yields nothing until its tlast byte returns the block to the start. With
// bypass set every byte is copied as it stands. Write the configuration only while
// the block is idle.
module gzip_header_name_padder_unit #(
    parameter int unsigned MAX_PAD = 62        // 1 .. 62
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,               // [7:0] in_byte
    input  logic        s_tlast,               // in_end
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [gzhp_pkg::OUT_TDATA_W-1:0] m_tdata,
                        // [7:0] out_byte, [8] has_byte, [11:9] error_code,
                        // [12] run_last, [15:13] zero
    output logic        m_tlast                // file_end
);
    import gzhp_pkg::*;

    localparam logic [5:0] MaxPadL = 6'(MAX_PAD);

    typedef enum logic [2:0] {
        PH_MAGIC1, PH_MAGIC2, PH_METHOD, PH_FLAG,
        PH_HEADER, PH_SKIPNAME, PH_PASS, PH_DROP
    } phase_t;

    // ---------------- configuration ----------------
    logic [5:0] pad_count_reg;
    logic       bypass_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_count_reg <= '0;
            bypass_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PAD_COUNT: pad_count_reg <= cfg_wdata;
                CFG_BYPASS:    bypass_reg    <= cfg_wdata[0];
                default:       ;
            endcase
        end
    end

    // ---------------- input buffer ----------------
    logic [7:0] fifo_byte_reg [2];
    logic       fifo_end_reg  [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    // ---------------- decode and output ----------------
    phase_t     phase_reg, phase_next;
    logic [2:0] header_left_reg, header_left_next;
    logic       had_name_reg, had_name_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       has_reg, has_next;
    err_code_t  err_reg, err_next;
    logic       run_last_reg, run_last_next;
    logic       file_end_reg, file_end_next;
    logic [5:0] pad_left_reg, pad_left_next;
    logic       pend_reg, pend_next;           // padding burst still owes its NUL
    logic       pend_end_reg, pend_end_next;   // burst closes the file

    logic       out_free;
    logic [7:0] b;
    logic       e;
    logic       first_vld;
    logic [7:0] first_byte;
    logic       first_has;
    err_code_t  first_err;
    logic       closed;
    logic       pad_due;
    logic [2:0] hl_dec;
    logic [5:0] pad_n;

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign pop      = (count_reg != 2'd0) && !pend_reg && out_free;
    assign count_next = count_reg + 2'(push) - 2'(pop);

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_byte_reg[wr_ptr_reg] <= s_tdata;
            fifo_end_reg[wr_ptr_reg]  <= s_tlast;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    assign b      = fifo_byte_reg[rd_ptr_reg];
    assign e      = fifo_end_reg[rd_ptr_reg];
    assign hl_dec = header_left_reg - 3'd1;
    assign pad_n  = (pad_count_reg > MaxPadL) ? MaxPadL : pad_count_reg;

    // Decode the head byte against the header phase
    always_comb begin
        first_vld        = 1'b0;
        first_byte       = GZ_NUL;
        first_has        = 1'b0;
        first_err        = ERR_NONE;
        closed           = 1'b0;
        pad_due          = 1'b0;
        phase_next       = phase_reg;
        header_left_next = header_left_reg;
        had_name_next    = had_name_reg;

        if (bypass_reg) begin
            first_vld  = 1'b1;
            first_byte = b;
            first_has  = 1'b1;
        end else begin
            case (phase_reg)
                PH_MAGIC1: begin
                    first_vld = 1'b1;
                    if (b == GZ_MAGIC1) begin
                        first_byte = b;
                        first_has  = 1'b1;
                        phase_next = PH_MAGIC2;
                    end else begin
                        first_err  = ERR_MAGIC1;
                        closed     = 1'b1;
                        phase_next = PH_DROP;
                    end
                end
                PH_MAGIC2: begin
                    first_vld = 1'b1;
                    if (b == GZ_MAGIC2) begin
                        first_byte = b;
                        first_has  = 1'b1;
                        phase_next = PH_METHOD;
                    end else begin
                        first_err  = ERR_MAGIC2;
                        closed     = 1'b1;
                        phase_next = PH_DROP;
                    end
                end
                PH_METHOD: begin
                    first_vld = 1'b1;
                    if (b == GZ_METHOD_DEFL) begin
                        first_byte = b;
                        first_has  = 1'b1;
                        phase_next = PH_FLAG;
                    end else begin
                        first_err  = ERR_METHOD;
                        closed     = 1'b1;
                        phase_next = PH_DROP;
                    end
                end
                PH_FLAG: begin
                    first_vld = 1'b1;
                    if (b == GZ_NUL) begin
                        // no flags: claim FNAME and insert a name later
                        first_byte       = GZ_FLAG_FNAME;
                        first_has        = 1'b1;
                        had_name_next    = 1'b0;
                        header_left_next = GZ_HEADER_BYTES;
                        phase_next       = PH_HEADER;
                    end else if ((b & GZ_FLAG_FNAME) != GZ_NUL) begin
                        first_byte       = b;
                        first_has        = 1'b1;
                        had_name_next    = 1'b1;
                        header_left_next = GZ_HEADER_BYTES;
                        phase_next       = PH_HEADER;
                    end else begin
                        first_err  = ERR_FLAG;
                        closed     = 1'b1;
                        phase_next = PH_DROP;
                    end
                end
                PH_HEADER: begin
                    first_vld        = 1'b1;
                    first_byte       = b;
                    first_has        = 1'b1;
                    header_left_next = hl_dec;
                    if (hl_dec == 3'd0) begin
                        if (had_name_reg) begin
                            phase_next = PH_SKIPNAME;
                        end else begin
                            pad_due    = 1'b1;
                            phase_next = PH_PASS;
                        end
                    end
                end
                PH_SKIPNAME: begin
                    // drop the old name; its NUL triggers the new one
                    if (b == GZ_NUL) begin
                        pad_due    = 1'b1;
                        phase_next = PH_PASS;
                    end
                end
                PH_PASS: begin
                    first_vld  = 1'b1;
                    first_byte = b;
                    first_has  = 1'b1;
                end
                PH_DROP: begin
                    closed = 1'b1;
                end
                default: begin
                    phase_next = PH_MAGIC1;
                end
            endcase
        end

        if (e) begin
            phase_next       = PH_MAGIC1;
            header_left_next = 3'd0;
            had_name_next    = 1'b0;
        end
    end

    // Load the output register from the burst or from a fresh byte
    always_comb begin
        m_valid_next  = m_valid_reg && !m_tready;
        out_byte_next = out_byte_reg;
        has_next      = has_reg;
        err_next      = err_reg;
        run_last_next = run_last_reg;
        file_end_next = file_end_reg;
        pad_left_next = pad_left_reg;
        pend_next     = pend_reg;
        pend_end_next = pend_end_reg;

        if (pend_reg && out_free) begin
            m_valid_next = 1'b1;
            has_next     = 1'b1;
            err_next     = ERR_NONE;
            if (pad_left_reg != 6'd0) begin
                out_byte_next = GZ_PAD_CHAR;
                pad_left_next = pad_left_reg - 6'd1;
                run_last_next = 1'b0;
                file_end_next = 1'b0;
            end else begin
                out_byte_next = GZ_NUL;
                pend_next     = 1'b0;
                run_last_next = 1'b1;
                file_end_next = pend_end_reg;
            end
        end else if (pop) begin
            pend_end_next = e;
            if (first_vld) begin
                m_valid_next  = 1'b1;
                out_byte_next = first_byte;
                has_next      = first_has;
                err_next      = first_err;
                run_last_next = !pad_due;
                file_end_next = !pad_due && (e || (first_err != ERR_NONE));
                pend_next     = pad_due;
                pad_left_next = pad_n;
            end else if (pad_due) begin
                m_valid_next = 1'b1;
                has_next     = 1'b1;
                err_next     = ERR_NONE;
                if (pad_n != 6'd0) begin
                    out_byte_next = GZ_PAD_CHAR;
                    pad_left_next = pad_n - 6'd1;
                    pend_next     = 1'b1;
                    run_last_next = 1'b0;
                    file_end_next = 1'b0;
                end else begin
                    out_byte_next = GZ_NUL;
                    pend_next     = 1'b0;
                    run_last_next = 1'b1;
                    file_end_next = e;
                end
            end else if (e && !closed) begin
                // end of file with nothing else to say: close the stream
                m_valid_next  = 1'b1;
                out_byte_next = GZ_NUL;
                has_next      = 1'b0;
                err_next      = ERR_NONE;
                run_last_next = 1'b1;
                file_end_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
        has_reg      <= has_next;
        err_reg      <= err_next;
        run_last_reg <= run_last_next;
        file_end_reg <= file_end_next;
        pad_left_reg <= pad_left_next;
        pend_end_reg <= pend_end_next;
        if (!aresetn) begin
            phase_reg       <= PH_MAGIC1;
            header_left_reg <= 3'd0;
            had_name_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            pend_reg        <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg       <= phase_next;
                header_left_reg <= header_left_next;
                had_name_reg    <= had_name_next;
            end
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = file_end_reg;
    assign m_tdata  = {3'b000, run_last_reg, err_reg, has_reg, out_byte_reg};

endmodule

[hw/rtl/gzhp_checker.sv]
// Port-level checker for the gzip header name padder, bound to its top level.
// Depends on gzhp_pkg and gzip_header_name_padder_unit.
`timescale 1ns / 1ps

module gzhp_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [gzhp_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tlast
);
    import gzhp_pkg::*;

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // a result that closes the file also closes its run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[OUT_LAST_BIT])
        else $error("file end without run end");

    // an error result carries no byte and closes the file
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[OUT_ERR_LSB +: 3] != ERR_NONE)
            |-> !m_tdata[OUT_HAS_BIT] && m_tlast && (m_tdata[OUT_BYTE_LSB +: 8] == GZ_NUL))
        else $error("malformed error result");

    // a result without a byte is an error or an end marker, never mid-run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[OUT_HAS_BIT] |-> m_tlast && m_tdata[OUT_LAST_BIT])
        else $error("empty result inside a run");

    // reset empties the result channel
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present after reset");

endmodule

bind gzip_header_name_padder_unit gzhp_checker u_gzhp_checker (.*);
